// ----- hdl/bdq_pkg.sv -----
`timescale 1ns / 1ps

package bdq_pkg;

	// default ring depth
	localparam int DEF_CAPACITY = 64;

	// field widths
	localparam int OP_W     = 3;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 7;

	// operation codes
	localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
	localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
	localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
	localparam logic [OP_W-1:0] OP_SEARCH     = 3'd4;
	localparam logic [OP_W-1:0] OP_DELETE     = 3'd5;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

endpackage

// ----- hdl/bounded_deque_with_search.sv -----
`timescale 1ns / 1ps

// Bounded double-ended queue of signed 32-bit values with search and delete.
// Input stream s_*: one word per operation; s_tuser carries the opcode
// (push front/back, pop front/back, search, delete first match), s_tdata the
// operand. Output stream m_*: exactly one word per operation, in order:
// value (popped or deleted), found flag, status and entry count.
// Storage is a ring of CAPACITY words in a single-port-write RAM with a
// registered read; one read/compare/move path is reused for every step.
// Path from accept to m_tvalid:
//   push, op on an empty ring, push into a full ring, unknown opcode: result
//   registered at accept; pop: one RAM read, then the result
//   search: scan from the front, one entry compared per cycle
//   delete: scan as for search, then shift the entries behind the match
//           one place toward the front to close the gap
// The block takes one operation at a time; s_tready is low while a walk is
// in progress and while an undelivered result sits in the output register
// with m_tready low. A stalled receiver simply holds the result and the
// next operation waits. Reset empties the queue (front and count to zero);
// RAM contents are not cleared, entries are only read after being pushed.
module bounded_deque_with_search #(
	parameter int CAPACITY = bdq_pkg::DEF_CAPACITY
) (
	input  logic        clk,
	input  logic        arst_n,
	// input words
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tuser,   // [2:0] operation, [7:3] zero
	input  logic [31:0] s_tdata,   // [31:0] operand_value
	// result words
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [2:0]  m_tuser,   // [0] found, [2:1] status
	output logic [39:0] m_tdata    // [31:0] result_value, [38:32] entry_count, [39] zero
);

	import bdq_pkg::*;

	localparam int IW = $clog2(CAPACITY);      // ring index
	localparam int CW = $clog2(CAPACITY + 1);  // occupancy, 0..CAPACITY
	localparam int AW = CW + 1;                // index + offset sum

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD,
		S_SCAN,
		S_SHIFT
	} state_t;

	state_t state_q;

	logic [IW-1:0]       front_q;
	logic [CW-1:0]       occ_q;
	logic [OP_W-1:0]     op_q;
	logic [VALUE_W-1:0]  val_q;

	// walk registers, shared by scan and shift
	logic [IW-1:0]       ptr_q;       // next ring position to read
	logic [CW-1:0]       j_q;         // offset of next read
	logic [IW-1:0]       dst_q;       // shift: where the next read lands
	logic                pend_vld_q;  // a read is in flight
	logic [IW-1:0]       pend_pos_q;  // its ring position (scan) or target (shift)
	logic [IW-1:0]       pend_off_q;  // its offset from front (scan)

	// output register
	logic                out_vld_q;
	logic [VALUE_W-1:0]  out_value_q;
	logic                out_found_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [COUNT_W-1:0]  out_count_q;

	// RAM port
	logic                ram_we;
	logic [IW-1:0]       ram_waddr;
	logic [VALUE_W-1:0]  ram_wdata;
	logic [IW-1:0]       ram_raddr;
	logic [VALUE_W-1:0]  ram_rdata;

	logic                s_accept;
	logic [OP_W-1:0]     s_op;
	logic                full;
	logic                empty;
	logic                match;
	logic [IW-1:0]       front_dec;
	logic [IW-1:0]       back_pos;   // last held entry
	logic [IW-1:0]       tail_pos;   // first free slot

	function automatic logic [IW-1:0] ring_inc(input logic [IW-1:0] p);
		return (p == IW'(CAPACITY - 1)) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [IW-1:0] ring_dec(input logic [IW-1:0] p);
		return (p == '0) ? IW'(CAPACITY - 1) : p - 1'b1;
	endfunction

	// front + off, wrapped; off < CAPACITY
	function automatic logic [IW-1:0] ring_add(input logic [IW-1:0] base,
	                                           input logic [CW-1:0] off);
		logic [AW-1:0] s;
		s = AW'(base) + AW'(off);
		if (s >= AW'(CAPACITY)) begin
			s = s - AW'(CAPACITY);
		end
		return IW'(s);
	endfunction

	assign s_tready = (state_q == S_IDLE) && (!out_vld_q || m_tready);
	assign s_accept = s_tvalid && s_tready;
	assign s_op     = s_tuser[OP_W-1:0];

	assign full      = (occ_q == CW'(CAPACITY));
	assign empty     = (occ_q == '0);
	assign front_dec = ring_dec(front_q);
	assign back_pos  = ring_add(front_q, occ_q - 1'b1);
	assign tail_pos  = ring_add(front_q, full ? '0 : occ_q);
	assign match     = pend_vld_q && (ram_rdata == val_q);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = pend_pos_q;
		ram_wdata = ram_rdata;
		ram_raddr = ptr_q;
		case (state_q)
			S_IDLE: begin
				ram_wdata = s_tdata;
				ram_raddr = (s_op == OP_POP_BACK) ? back_pos : front_q;
				if (s_accept && !full) begin
					if (s_op == OP_PUSH_FRONT) begin
						ram_we    = 1'b1;
						ram_waddr = front_dec;
					end else if (s_op == OP_PUSH_BACK) begin
						ram_we    = 1'b1;
						ram_waddr = tail_pos;
					end
				end
			end
			S_SHIFT: begin
				ram_we = pend_vld_q;
			end
			default: begin
			end
		endcase
	end

	bdq_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			front_q      <= '0;
			occ_q        <= '0;
			pend_vld_q   <= 1'b0;
			out_vld_q    <= 1'b0;
			op_q         <= '0;
			val_q        <= '0;
			ptr_q        <= '0;
			j_q          <= '0;
			dst_q        <= '0;
			pend_pos_q   <= '0;
			pend_off_q   <= '0;
			out_value_q  <= '0;
			out_found_q  <= 1'b0;
			out_status_q <= ST_OK;
			out_count_q  <= '0;
		end else begin
			if (out_vld_q && m_tready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_accept) begin
						op_q         <= s_op;
						val_q        <= s_tdata;
						ptr_q        <= front_q;
						j_q          <= '0;
						pend_vld_q   <= 1'b0;
						out_value_q  <= '0;
						out_found_q  <= 1'b0;
						out_status_q <= ST_OK;
						out_count_q  <= COUNT_W'(occ_q);
						case (s_op)
							OP_PUSH_FRONT, OP_PUSH_BACK: begin
								out_vld_q <= 1'b1;
								if (full) begin
									out_status_q <= ST_FULL;
								end else begin
									if (s_op == OP_PUSH_FRONT) begin
										front_q <= front_dec;
									end
									occ_q       <= occ_q + 1'b1;
									out_count_q <= COUNT_W'(occ_q + 1'b1);
								end
							end
							OP_POP_FRONT, OP_POP_BACK: begin
								if (empty) begin
									out_vld_q    <= 1'b1;
									out_status_q <= ST_EMPTY;
								end else begin
									if (s_op == OP_POP_FRONT) begin
										front_q <= ring_inc(front_q);
									end
									occ_q   <= occ_q - 1'b1;
									state_q <= S_RD;
								end
							end
							OP_SEARCH, OP_DELETE: begin
								if (empty) begin
									out_vld_q    <= 1'b1;
									out_status_q <= (s_op == OP_SEARCH) ? ST_NOT_FOUND
									                                    : ST_EMPTY;
								end else begin
									state_q <= S_SCAN;
								end
							end
							default: begin
								out_vld_q <= 1'b1;
							end
						endcase
					end
				end
				S_RD: begin
					// read issued at accept, count already updated
					out_vld_q    <= 1'b1;
					out_value_q  <= ram_rdata;
					out_count_q  <= COUNT_W'(occ_q);
					state_q      <= S_IDLE;
				end
				S_SCAN: begin
					if (match) begin
						pend_vld_q <= 1'b0;
						if (op_q == OP_SEARCH) begin
							out_vld_q   <= 1'b1;
							out_found_q <= 1'b1;
							state_q     <= S_IDLE;
						end else begin
							// close the gap: entry off+1 moves to off, and so on
							dst_q   <= pend_pos_q;
							ptr_q   <= ring_inc(pend_pos_q);
							j_q     <= CW'(pend_off_q) + 1'b1;
							state_q <= S_SHIFT;
						end
					end else if (j_q < occ_q) begin
						ptr_q      <= ring_inc(ptr_q);
						j_q        <= j_q + 1'b1;
						pend_vld_q <= 1'b1;
						pend_pos_q <= ptr_q;
						pend_off_q <= IW'(j_q);
					end else begin
						pend_vld_q <= 1'b0;
						if (!pend_vld_q) begin
							out_vld_q    <= 1'b1;
							out_status_q <= ST_NOT_FOUND;
							state_q      <= S_IDLE;
						end
					end
				end
				S_SHIFT: begin
					if (j_q < occ_q) begin
						ptr_q      <= ring_inc(ptr_q);
						j_q        <= j_q + 1'b1;
						pend_vld_q <= 1'b1;
						pend_pos_q <= dst_q;
						dst_q      <= ptr_q;
					end else begin
						pend_vld_q <= 1'b0;
						if (!pend_vld_q) begin
							occ_q       <= occ_q - 1'b1;
							out_vld_q   <= 1'b1;
							out_value_q <= val_q;
							out_found_q <= 1'b1;
							out_count_q <= COUNT_W'(occ_q - 1'b1);
							state_q     <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tuser  = {out_status_q, out_found_q};
	assign m_tdata  = {1'b0, out_count_q, out_value_q};

	// occupancy stays within the ring
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CW'(CAPACITY))
		else $error("occupancy above capacity");

	// full is only reported when the ring is actually full
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(s_accept && (s_op == OP_PUSH_FRONT || s_op == OP_PUSH_BACK) && !full)
		|=> (out_status_q == ST_OK && occ_q == $past(occ_q) + 1'b1))
		else $error("push into free ring not counted");

	// RAM writes in idle come only from an accepted push
	a_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && state_q == S_IDLE) |-> (s_accept && !full))
		else $error("stray RAM write");

	// reads in flight exist only while walking the ring
	a_pend_walk: assert property (@(posedge clk) disable iff (!arst_n)
		pend_vld_q |-> (state_q == S_SCAN || state_q == S_SHIFT))
		else $error("pending read outside walk");

	// a found result always carries ok status
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && out_found_q) |-> (out_status_q == ST_OK))
		else $error("found with bad status");

	// a result is never loaded over an undelivered one
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !m_tready) |-> !s_tready)
		else $error("input taken while result stalled");

endmodule

// ----- hdl/bdq_ram.sv -----
`timescale 1ns / 1ps

// single write port, one registered read port
module bdq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- dv/bounded_deque_with_search_tb.sv -----
`timescale 1ns / 1ps

module bounded_deque_with_search_tb;

	import bdq_pkg::*;

	localparam int DEPTH          = DEF_CAPACITY;
	localparam int RANDOM_WORDS   = 1000;
	localparam int CYCLE_LIMIT    = 1_000_000;
	// longest walk is a delete near the front of a full ring
	localparam int SETTLE_CYCLES  = 2 * DEPTH + 16;
	localparam int REPORT_LIMIT   = 10;
	localparam int LONG_HOLD      = 500;
	localparam int HOLD_AFTER     = 300;

	// opcodes the block must ignore
	localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

	localparam logic [31:0] INT_MIN = 32'h8000_0000;
	localparam logic [31:0] INT_MAX = 32'h7fff_ffff;

	typedef struct packed {
		logic [VALUE_W-1:0]  value;
		logic                found;
		logic [STATUS_W-1:0] status;
		logic [COUNT_W-1:0]  count;
	} deque_result_t;

	typedef struct {
		logic [OP_W-1:0]    op;
		logic [VALUE_W-1:0] value;
		bit                 drain_first;  // wait until every result is back
	} op_word_t;

	typedef enum int {RX_FREE, RX_HALF, RX_SLOW, RX_RARE_STALL} rx_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tuser = '0;   // [2:0] operation, [7:3] zero
	logic [31:0] s_tdata = '0;   // [31:0] operand_value
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [2:0]  m_tuser;        // [0] found, [2:1] status
	logic [39:0] m_tdata;        // [31:0] result_value, [38:32] entry_count, [39] zero

	// stimulus not yet offered, and results owed by the block
	op_word_t      pending_words[$];
	deque_result_t predicted_results[$];

	// shadow copy of the held entries, front at index 0
	logic [VALUE_W-1:0] deque_model[$];

	int error_count   = 0;
	int results_seen  = 0;
	int cycle_count   = 0;
	int op_tally[8];
	int full_hits     = 0;
	int empty_hits    = 0;
	int match_hits    = 0;
	int miss_hits     = 0;
	int peak_depth    = 0;

	bounded_deque_with_search #(
		.CAPACITY(DEPTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tuser  (m_tuser),
		.m_tdata  (m_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Predict one word's result and advance the shadow deque.
	// Search/delete match the first equal entry counted from the front.
	function automatic deque_result_t model_deque_op(logic [OP_W-1:0] op,
			logic [VALUE_W-1:0] operand);
		deque_result_t r;
		int hit;
		r = '0;
		r.status = ST_OK;
		hit = -1;
		if (op == OP_SEARCH || op == OP_DELETE) begin
			foreach (deque_model[i])
				if (hit < 0 && deque_model[i] == operand)
					hit = i;
		end
		op_tally[op]++;
		case (op)
			OP_PUSH_FRONT, OP_PUSH_BACK: begin
				if (deque_model.size() >= DEPTH) begin
					r.status = ST_FULL;
					full_hits++;
				end else if (op == OP_PUSH_FRONT) begin
					deque_model.push_front(operand);
				end else begin
					deque_model.push_back(operand);
				end
			end
			OP_POP_FRONT, OP_POP_BACK: begin
				if (deque_model.size() == 0) begin
					r.status = ST_EMPTY;
					empty_hits++;
				end else if (op == OP_POP_FRONT) begin
					r.value = deque_model.pop_front();
				end else begin
					r.value = deque_model.pop_back();
				end
			end
			OP_SEARCH: begin
				// an empty ring is simply a miss here
				if (hit >= 0) begin
					r.found = 1'b1;
					match_hits++;
				end else begin
					r.status = ST_NOT_FOUND;
					miss_hits++;
				end
			end
			OP_DELETE: begin
				if (deque_model.size() == 0) begin
					r.status = ST_EMPTY;
					empty_hits++;
				end else if (hit >= 0) begin
					r.value = deque_model[hit];
					r.found = 1'b1;
					deque_model.delete(hit);
					match_hits++;
				end else begin
					r.status = ST_NOT_FOUND;
					miss_hits++;
				end
			end
			default: ;
		endcase
		r.count = COUNT_W'(deque_model.size());
		if (deque_model.size() > peak_depth)
			peak_depth = deque_model.size();
		return r;
	endfunction

	task automatic queue_op(logic [OP_W-1:0] op, logic [VALUE_W-1:0] value,
			bit drain_first = 1'b0);
		op_word_t w;
		w.op = op;
		w.value = value;
		w.drain_first = drain_first;
		pending_words.push_back(w);
	endtask

	// Mostly a small pool so searches and deletes hit held entries.
	function automatic logic [VALUE_W-1:0] pick_value();
		logic [VALUE_W-1:0] pool[12];
		pool = '{32'd0, 32'd1, 32'hffff_ffff, INT_MIN, INT_MAX, 32'd5, 32'd42,
			32'h5555_5555, 32'haaaa_aaaa, 32'd100, 32'hffff_ff9c, 32'd7};
		if ($urandom_range(0, 99) < 65)
			return pool[$urandom_range(0, 11)];
		return $urandom();
	endfunction

	task automatic flag_error(string msg);
		error_count++;
		if (error_count <= REPORT_LIMIT)
			$display("%0t ns: %s", $realtime, msg);
	endtask

	// Stimulus: directed corner cases, then episodes of fill / drain / mixed.
	initial begin : stimulus
		int n_random;
		int episode;
		int ep_len;
		int roll;
		logic [OP_W-1:0] op;

		// empty-ring behavior and the two spare opcodes
		queue_op(OP_POP_FRONT, 32'd0);
		queue_op(OP_DELETE, 32'd0);
		queue_op(OP_SEARCH, 32'd0);
		queue_op(OP_SPARE_6, 32'hdead_beef);
		queue_op(OP_SPARE_7, 32'h1234_5678);
		// extremes through both ends
		queue_op(OP_PUSH_FRONT, INT_MIN);
		queue_op(OP_PUSH_BACK, INT_MAX);
		queue_op(OP_PUSH_BACK, 32'd0);
		queue_op(OP_PUSH_FRONT, 32'hffff_ffff);
		queue_op(OP_SEARCH, INT_MAX);
		queue_op(OP_SEARCH, 32'd1);
		queue_op(OP_DELETE, 32'd0);
		// duplicates: a delete of a value held twice, a missed delete, then drain
		queue_op(OP_PUSH_BACK, 32'd5);
		queue_op(OP_PUSH_BACK, 32'd5);
		queue_op(OP_DELETE, 32'd5);
		queue_op(OP_DELETE, 32'd99);
		queue_op(OP_POP_FRONT, 32'd0);
		queue_op(OP_POP_BACK, 32'd0);
		queue_op(OP_POP_BACK, 32'd0);
		queue_op(OP_POP_FRONT, 32'd0);
		queue_op(OP_POP_BACK, 32'd0);

		n_random = 0;
		episode = 0;
		while (n_random < RANDOM_WORDS) begin
			// first episode always fills, so the full ring shows up early
			roll = (episode == 0) ? 0 : $urandom_range(0, 2);
			ep_len = $urandom_range(40, 90);
			for (int k = 0; k < ep_len; k++) begin
				case (roll)
					0: begin
						// fill: mostly pushes, some lookups
						op = ($urandom_range(0, 99) < 42) ? OP_PUSH_FRONT :
							($urandom_range(0, 99) < 85) ? OP_PUSH_BACK :
							($urandom_range(0, 1) == 1) ? OP_SEARCH : OP_DELETE;
					end
					1: begin
						// drain: mostly pops, runs past empty
						op = ($urandom_range(0, 99) < 40) ? OP_POP_FRONT :
							($urandom_range(0, 99) < 80) ? OP_POP_BACK :
							($urandom_range(0, 1) == 1) ? OP_DELETE : OP_SEARCH;
					end
					default: begin
						op = ($urandom_range(0, 99) < 5) ? OP_W'($urandom_range(6, 7)) :
							OP_W'($urandom_range(0, 5));
					end
				endcase
				queue_op(op, pick_value(), (k == 0) && (episode % 5 == 4));
				if (op != OP_SPARE_6 && op != OP_SPARE_7)
					n_random++;
			end
			episode++;
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_words.size() != 0 || s_tvalid || predicted_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		foreach (predicted_results[i])
			flag_error($sformatf("result never delivered: value=%h found=%b status=%0d count=%0d",
				predicted_results[i].value, predicted_results[i].found,
				predicted_results[i].status, predicted_results[i].count));

		$display("covered %0d results: push f/b %0d/%0d, pop f/b %0d/%0d, search %0d, delete %0d, spare %0d",
			results_seen, op_tally[0], op_tally[1], op_tally[2], op_tally[3],
			op_tally[4], op_tally[5], op_tally[6] + op_tally[7]);
		$display("full %0d, empty %0d, matches %0d, misses %0d, peak depth %0d of %0d; %0d errors",
			full_hits, empty_hits, match_hits, miss_hits, peak_depth, DEPTH, error_count);
		if (error_count == 0)
			$display("bounded_deque_with_search_tb: done, clean");
		else
			$display("bounded_deque_with_search_tb: done, errors");
		$finish;
	end

	// Sender: bursts of random length with random gaps; a flagged word waits
	// for the block to drain completely before it is offered.
	always @(posedge clk or negedge arst_n) begin : op_driver
		op_word_t w;
		logic offer_next;
		logic [OP_W-1:0] op_next;
		logic [VALUE_W-1:0] value_next;
		int burst_left;
		int gap_left;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tuser <= '0;
			s_tdata <= '0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			offer_next = s_tvalid;
			op_next = s_tuser[OP_W-1:0];
			value_next = s_tdata;
			if (s_tvalid && s_tready) begin
				predicted_results.push_back(model_deque_op(s_tuser[OP_W-1:0], s_tdata));
				offer_next = 1'b0;
				if (burst_left > 0)
					burst_left--;
				if (burst_left == 0) begin
					// some long bursts give stretches with no sender idling
					burst_left = ($urandom_range(0, 3) == 0) ?
						$urandom_range(50, 150) : $urandom_range(1, 12);
					gap_left = $urandom_range(1, 9);
				end
			end
			if (!offer_next) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_words.size() != 0 &&
						!(pending_words[0].drain_first && predicted_results.size() != 0)) begin
					w = pending_words.pop_front();
					offer_next = 1'b1;
					op_next = w.op;
					value_next = w.value;
				end
			end
			s_tvalid <= offer_next;
			s_tuser <= {5'b0, op_next};
			s_tdata <= value_next;
		end
	end

	// Receiver: switches between random stall patterns, and once
	// holds off for a long stretch so the block backs up its input.
	always @(posedge clk or negedge arst_n) begin : result_sink
		rx_mode_t mode;
		int mode_left;
		int hold_left;
		bit hold_done;
		logic ready_next;
		if (!arst_n) begin
			m_tready <= 1'b0;
			mode = RX_FREE;
			mode_left = 0;
			hold_left = 0;
			hold_done = 1'b0;
		end else begin
			if (hold_left > 0) begin
				hold_left--;
				ready_next = 1'b0;
			end else if (!hold_done && results_seen >= HOLD_AFTER) begin
				hold_done = 1'b1;
				hold_left = LONG_HOLD;
				ready_next = 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode = rx_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(20, 300);
				end
				mode_left--;
				case (mode)
					RX_FREE:       ready_next = 1'b1;
					RX_HALF:       ready_next = 1'($urandom_range(0, 1));
					RX_SLOW:       ready_next = ($urandom_range(0, 3) == 0);
					default:       ready_next = ($urandom_range(0, 7) != 0);
				endcase
			end
			m_tready <= ready_next;
		end
	end

	// Compare every delivered word with the oldest prediction.
	always @(posedge clk) begin : result_monitor
		deque_result_t got;
		deque_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.value = m_tdata[31:0];
			got.count = m_tdata[38:32];
			got.found = m_tuser[0];
			got.status = m_tuser[2:1];
			results_seen++;
			if (predicted_results.size() == 0) begin
				flag_error($sformatf("unexpected result: value=%h found=%b status=%0d count=%0d",
					got.value, got.found, got.status, got.count));
			end else begin
				want = predicted_results.pop_front();
				if (got.value !== want.value || got.found !== want.found ||
						got.status !== want.status || got.count !== want.count)
					flag_error($sformatf({"result %0d mismatch: value %h/%h found %b/%b",
						" status %0d/%0d count %0d/%0d (expected/actual)"},
						results_seen, want.value, got.value, want.found, got.found,
						want.status, got.status, want.count, got.count));
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results seen", cycle_count, results_seen);
			$display("bounded_deque_with_search_tb: done, errors");
			$finish;
		end
	end

endmodule

// ----- bounded_deque_with_search.f -----
hdl/bdq_pkg.sv
hdl/bdq_ram.sv
hdl/bounded_deque_with_search.sv
dv/bounded_deque_with_search_tb.sv
